[hdl/pwpa_pkg.sv]
// shared types, constants and the arctangent table for the plane wave phase accumulator
`timescale 1ns / 1ps

package pwpa_pkg;

   // one turn is 2^32; round(2^32 / (2*pi))
   localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
   // inverse of the limit gain of the rotation in q.30
   localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
   localparam int ATAN_LEN = 24;

   // atan(2^-i) as a 32-bit binary angle
   localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   // fields that ride along untouched until the final add
   typedef struct packed {
      logic        [23:0] amp;
      logic signed [47:0] fre;
      logic signed [47:0] fim;
   } carry_type;

   // rotation state plus the carried fields
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               flip;
      carry_type          carry;
   } work_type;

endpackage

[hdl/pwpa_phase.sv]
// phase products, sum, reduction to turns and half turn fold (four register stages)
`timescale 1ns / 1ps

module pwpa_phase
   import pwpa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic signed [31:0] x_coord,
   input  logic signed [31:0] y_coord,
   input  logic signed [17:0] dir_x,
   input  logic signed [17:0] dir_y,
   input  carry_type          carry,
   output logic               out_valid,
   input  logic               out_ready,
   output work_type           out_work
);

   logic vld_a_ff, vld_b_ff, vld_c_ff, vld_d_ff;
   logic rdy_a, rdy_b, rdy_c, rdy_d;

   logic signed [49:0] prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   carry_type          carry_a_ff, carry_b_ff, carry_c_ff;
   logic signed [50:0] phase_ff, phase_in;
   logic        [31:0] hi_word, lo_word;
   logic        [63:0] hi_prod, lo_prod;
   logic        [31:0] hk_ff, hk_in, lk_ff, lk_in;
   logic        [31:0] angle;
   logic               flip;
   work_type           work_ff, work_in;

   // stall chain: a stage takes new data when empty or when its successor moves
   assign rdy_d    = !vld_d_ff || out_ready;
   assign rdy_c    = !vld_c_ff || rdy_d;
   assign rdy_b    = !vld_b_ff || rdy_c;
   assign rdy_a    = !vld_a_ff || rdy_b;
   assign in_ready = rdy_a;

   // stage a: the two direction products
   assign prod_x_in = 50'(x_coord) * 50'(dir_x);
   assign prod_y_in = 50'(y_coord) * 50'(dir_y);

   // stage b: exact phase in q.32 radians
   assign phase_in = 51'(prod_x_ff) + 51'(prod_y_ff);

   // stage c: split into words and scale both by the turn constant
   assign hi_word = {{13{phase_ff[50]}}, phase_ff[50:32]};
   assign lo_word = phase_ff[31:0];
   assign hi_prod = 64'(hi_word) * 64'(INV_TWO_PI_Q32);
   assign lo_prod = 64'(lo_word) * 64'(INV_TWO_PI_Q32);
   assign hk_in   = hi_prod[31:0];
   assign lk_in   = lo_prod[63:32];

   // stage d: binary angle, fold the left half plane by half a turn
   assign angle = hk_ff + lk_ff;
   assign flip  = angle[31] ^ angle[30];
   always_comb begin
      work_in       = '0;
      work_in.x     = CORDIC_GAIN_Q30;
      work_in.y     = '0;
      work_in.z     = $signed(angle ^ {flip, 31'b0});
      work_in.flip  = flip;
      work_in.carry = carry_c_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
         vld_d_ff <= 1'b0;
      end else begin
         if (rdy_a) vld_a_ff <= in_valid;
         if (rdy_b) vld_b_ff <= vld_a_ff;
         if (rdy_c) vld_c_ff <= vld_b_ff;
         if (rdy_d) vld_d_ff <= vld_c_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (rdy_a) begin
         prod_x_ff  <= prod_x_in;
         prod_y_ff  <= prod_y_in;
         carry_a_ff <= carry;
      end
      if (rdy_b) begin
         phase_ff   <= phase_in;
         carry_b_ff <= carry_a_ff;
      end
      if (rdy_c) begin
         hk_ff      <= hk_in;
         lk_ff      <= lk_in;
         carry_c_ff <= carry_b_ff;
      end
      if (rdy_d) begin
         work_ff    <= work_in;
      end
   end

   assign out_valid = vld_d_ff;
   assign out_work  = work_ff;

endmodule

[hdl/pwpa_cordic_stage.sv]
// one registered rotation step of the cordic
`timescale 1ns / 1ps

module pwpa_cordic_stage
   import pwpa_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  work_type in_work,
   output logic     out_valid,
   input  logic     out_ready,
   output work_type out_work
);

   logic               vld_ff;
   work_type           work_ff, work_in;
   logic signed [31:0] dx, dy;
   logic signed [31:0] step_angle;

   assign in_ready   = !vld_ff || out_ready;
   assign dx         = in_work.y >>> STAGE;
   assign dy         = in_work.x >>> STAGE;
   assign step_angle = $signed(ATAN_TURNS[STAGE]);

   // rotate toward zero residual angle
   always_comb begin
      work_in = in_work;
      if (!in_work.z[31]) begin
         work_in.x = in_work.x - dx;
         work_in.y = in_work.y + dy;
         work_in.z = in_work.z - step_angle;
      end else begin
         work_in.x = in_work.x + dx;
         work_in.y = in_work.y - dy;
         work_in.z = in_work.z + step_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_work  = work_ff;

endmodule

[hdl/pwpa_mix.sv]
// unfold, amplitude scaling, rounding and saturating field update (four register stages)
`timescale 1ns / 1ps

module pwpa_mix
   import pwpa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  work_type           in_work,
   output logic               out_valid,
   input  logic               out_ready,
   output logic signed [47:0] new_re,
   output logic signed [47:0] new_im
);

   localparam logic signed [56:0] HALF_LSB = 57'sd536870912;
   localparam logic signed [47:0] FIELD_MAX = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] FIELD_MIN = {1'b1, {47{1'b0}}};

   logic vld_a_ff, vld_b_ff, vld_c_ff, vld_d_ff;
   logic rdy_a, rdy_b, rdy_c, rdy_d;

   logic signed [31:0] cos_ff, cos_in, sin_ff, sin_in;
   carry_type          carry_a_ff, carry_b_ff, carry_c_ff;
   logic signed [24:0] amp_s;
   logic signed [56:0] pc_ff, pc_in, ps_ff, ps_in;
   logic signed [56:0] rnd_c, rnd_s;
   logic signed [26:0] tre_ff, tre_in, tim_ff, tim_in;
   logic signed [48:0] sum_re, sum_im;
   logic signed [47:0] re_ff, re_in, im_ff, im_in;

   assign rdy_d    = !vld_d_ff || out_ready;
   assign rdy_c    = !vld_c_ff || rdy_d;
   assign rdy_b    = !vld_b_ff || rdy_c;
   assign rdy_a    = !vld_a_ff || rdy_b;
   assign in_ready = rdy_a;

   // stage a: undo the half turn fold
   assign cos_in = in_work.flip ? -in_work.x : in_work.x;
   assign sin_in = in_work.flip ? -in_work.y : in_work.y;

   // stage b: amplitude times cos and sin, exact q.46
   assign amp_s = $signed({1'b0, carry_a_ff.amp});
   assign pc_in = 57'(amp_s) * 57'(cos_ff);
   assign ps_in = 57'(amp_s) * 57'(sin_ff);

   // stage c: round half up to q.16
   assign rnd_c  = pc_ff + HALF_LSB;
   assign rnd_s  = ps_ff + HALF_LSB;
   assign tre_in = $signed(rnd_c[56:30]);
   assign tim_in = $signed(rnd_s[56:30]);

   // stage d: add to the field and clamp to 48 bits
   assign sum_re = 49'(carry_c_ff.fre) + 49'(tre_ff);
   assign sum_im = 49'(carry_c_ff.fim) - 49'(tim_ff);
   always_comb begin
      if (sum_re[48] != sum_re[47]) begin
         re_in = sum_re[48] ? FIELD_MIN : FIELD_MAX;
      end else begin
         re_in = sum_re[47:0];
      end
      if (sum_im[48] != sum_im[47]) begin
         im_in = sum_im[48] ? FIELD_MIN : FIELD_MAX;
      end else begin
         im_in = sum_im[47:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
         vld_d_ff <= 1'b0;
      end else begin
         if (rdy_a) vld_a_ff <= in_valid;
         if (rdy_b) vld_b_ff <= vld_a_ff;
         if (rdy_c) vld_c_ff <= vld_b_ff;
         if (rdy_d) vld_d_ff <= vld_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         cos_ff     <= cos_in;
         sin_ff     <= sin_in;
         carry_a_ff <= in_work.carry;
      end
      if (rdy_b) begin
         pc_ff      <= pc_in;
         ps_ff      <= ps_in;
         carry_b_ff <= carry_a_ff;
      end
      if (rdy_c) begin
         tre_ff     <= tre_in;
         tim_ff     <= tim_in;
         carry_c_ff <= carry_b_ff;
      end
      if (rdy_d) begin
         re_ff      <= re_in;
         im_ff      <= im_in;
      end
   end

   assign out_valid = vld_d_ff;
   assign new_re    = re_ff;
   assign new_im    = im_ff;

endmodule

[hdl/plane_wave_phase_accumulate.sv]
// Plane wave phase accumulator: each transaction carries a grid point, a source
// direction, an amplitude and the current complex field; the block returns
// field + amplitude*(cos(p) - i*sin(p)) with p = x*dx + y*dy reduced to turns,
// each part saturated to 48 bits. It is a fully pipelined datapath that takes
// one transaction per clock while the sink is ready and returns one result per
// transaction in order. There are four stages of phase products, sum and
// turn reduction, one stage per cordic rotation, and four stages of unfold,
// amplitude multiply, rounding and saturating add. Stalls on the result side
// only hold the pipeline stages that are full; empty stages keep taking input.
`timescale 1ns / 1ps

module plane_wave_phase_accumulate
   import pwpa_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // x_coord[31:0], y_coord[63:32], dir_x[81:64], dir_y[99:82],
   // amplitude[123:100], field_re[171:124], field_im[219:172], zero[223:220]
   input  logic [223:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_re[47:0], new_im[95:48]
   output logic [95:0]  rsp_tdata
);

   carry_type          carry;
   logic               vld_chain [CORDIC_STAGES+1];
   logic               rdy_chain [CORDIC_STAGES+1];
   work_type           work_chain [CORDIC_STAGES+1];
   logic signed [47:0] new_re, new_im;

   // unpack the request
   assign carry.amp = req_tdata[123:100];
   assign carry.fre = $signed(req_tdata[171:124]);
   assign carry.fim = $signed(req_tdata[219:172]);

   pwpa_phase u_phase (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .x_coord   ($signed(req_tdata[31:0])),
      .y_coord   ($signed(req_tdata[63:32])),
      .dir_x     ($signed(req_tdata[81:64])),
      .dir_y     ($signed(req_tdata[99:82])),
      .carry     (carry),
      .out_valid (vld_chain[0]),
      .out_ready (rdy_chain[0]),
      .out_work  (work_chain[0])
   );

   // cordic rotations, one register stage each
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
      pwpa_cordic_stage #(
         .STAGE (g)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld_chain[g]),
         .in_ready  (rdy_chain[g]),
         .in_work   (work_chain[g]),
         .out_valid (vld_chain[g+1]),
         .out_ready (rdy_chain[g+1]),
         .out_work  (work_chain[g+1])
      );
   end

   pwpa_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_chain[CORDIC_STAGES]),
      .in_ready  (rdy_chain[CORDIC_STAGES]),
      .in_work   (work_chain[CORDIC_STAGES]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .new_re    (new_re),
      .new_im    (new_im)
   );

   assign rsp_tdata = {new_im, new_re};

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // an empty output stage lets the whole pipeline move
   assert property (@(posedge clock) disable iff (reset) !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output stage");

   // a ready sink never back-pressures the input
   assert property (@(posedge clock) disable iff (reset) rsp_tready |-> req_tready)
      else $error("input stalled while sink is ready");

endmodule

[test/plane_wave_phase_accumulate_test.sv]
// self-checking testbench for the plane wave phase accumulator
`timescale 1ns / 1ps

module plane_wave_phase_accumulate_test;
   import pwpa_pkg::*;

   localparam int STAGES = 16;
   localparam int RANDOM_ITEMS = 1550;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_CYCLES = STAGES + 24;
   localparam longint FIELD_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint FIELD_MIN = -FIELD_MAX - 1;

   // one grid point, one source, one amplitude and the current field
   typedef struct {
      logic signed [31:0] x_coord;
      logic signed [31:0] y_coord;
      logic signed [17:0] dir_x;
      logic signed [17:0] dir_y;
      logic        [23:0] amplitude;
      logic signed [47:0] field_re;
      logic signed [47:0] field_im;
   } wave_item_type;

   // updated complex field
   typedef struct {
      logic [47:0] new_re;
      logic [47:0] new_im;
   } field_sum_type;

   // expected field values in order, plus the mismatch count
   class field_scoreboard;
      field_sum_type pending_fields[$];
      int errors;
      int inputs_seen;
      int results_seen;
      int saturations;

      // field + amplitude * (cos(p) - i*sin(p)), saturated per part
      function field_sum_type accumulate_wave(wave_item_type it);
         longint xc, yc, dxv, dyv, amp, fre, fim;
         longint x, y, z, sx, sy, c, s, tre, tim, sre, sim;
         logic [63:0] ph, hi, lo;
         logic [31:0] ang, probe;
         bit flip;
         field_sum_type r;
         xc = it.x_coord;
         yc = it.y_coord;
         dxv = it.dir_x;
         dyv = it.dir_y;
         amp = longint'(it.amplitude);
         fre = it.field_re;
         fim = it.field_im;
         // exact phase in q.32 radians, then to turns modulo one turn
         ph = xc * dxv + yc * dyv;
         hi = ph >> 32;
         lo = ph & 64'hFFFF_FFFF;
         ang = hi * INV_TWO_PI_Q32 + ((lo * INV_TWO_PI_Q32) >> 32);
         // fold the left half plane onto the right
         probe = ang + 32'h4000_0000;
         flip = (probe >= 32'h8000_0000);
         if (flip)
            ang = ang + 32'h8000_0000;
         z = longint'(signed'(ang));
         x = longint'(CORDIC_GAIN_Q30);
         y = 0;
         for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
            sx = y >>> i;
            sy = x >>> i;
            if (z >= 0) begin
               x = x - sx;
               y = y + sy;
               z = z - longint'(ATAN_TURNS[i]);
            end else begin
               x = x + sx;
               y = y - sy;
               z = z + longint'(ATAN_TURNS[i]);
            end
         end
         c = flip ? -x : x;
         s = flip ? -y : y;
         // round half up from q.46 to q.16
         tre = (amp * c + 64'sd536870912) >>> 30;
         tim = (amp * s + 64'sd536870912) >>> 30;
         sre = fre + tre;
         sim = fim - tim;
         if (sre > FIELD_MAX || sre < FIELD_MIN)
            saturations++;
         if (sim > FIELD_MAX || sim < FIELD_MIN)
            saturations++;
         if (sre > FIELD_MAX) sre = FIELD_MAX;
         if (sre < FIELD_MIN) sre = FIELD_MIN;
         if (sim > FIELD_MAX) sim = FIELD_MAX;
         if (sim < FIELD_MIN) sim = FIELD_MIN;
         r.new_re = sre[47:0];
         r.new_im = sim[47:0];
         return r;
      endfunction

      function void note_input(wave_item_type it);
         pending_fields.push_back(accumulate_wave(it));
         inputs_seen++;
      endfunction

      task report(string msg);
         $display("%0t ns: error: %s", $time, msg);
         errors++;
      endtask

      task check_result(logic [95:0] data);
         field_sum_type want;
         results_seen++;
         if (pending_fields.size() == 0) begin
            report($sformatf("result %0d arrived with nothing outstanding", results_seen));
         end else begin
            want = pending_fields.pop_front();
            if (data[47:0] !== want.new_re)
               report($sformatf("result %0d new_re got %h want %h",
                  results_seen, data[47:0], want.new_re));
            if (data[95:48] !== want.new_im)
               report($sformatf("result %0d new_im got %h want %h",
                  results_seen, data[95:48], want.new_im));
         end
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [223:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;

   field_scoreboard sb;
   bit steady;
   int quiet_cycles;
   int directed_count;

   plane_wave_phase_accumulate #(.CORDIC_STAGES(STAGES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [223:0] pack_wave(wave_item_type it);
      return {4'b0, it.field_im, it.field_re, it.amplitude,
              it.dir_y, it.dir_x, it.y_coord, it.x_coord};
   endfunction

   function automatic wave_item_type make_wave(longint x, longint y, longint dx, longint dy,
                                               longint amp, longint fre, longint fim);
      wave_item_type it;
      it.x_coord = x[31:0];
      it.y_coord = y[31:0];
      it.dir_x = dx[17:0];
      it.dir_y = dy[17:0];
      it.amplitude = amp[23:0];
      it.field_re = fre[47:0];
      it.field_im = fim[47:0];
      return it;
   endfunction

   // field value: mostly uniform, sometimes close to either rail or to zero
   function automatic longint random_field();
      longint v;
      int roll;
      roll = $urandom_range(99);
      if (roll < 15)
         v = FIELD_MAX - longint'($urandom_range(32'h0200_0000));
      else if (roll < 30)
         v = FIELD_MIN + longint'($urandom_range(32'h0200_0000));
      else if (roll < 45)
         v = longint'($signed($urandom_range(32'h00FF_FFFF))) - 64'sd8388608;
      else
         v = {$urandom, $urandom};
      return v;
   endfunction

   function automatic longint random_dir();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70)
         return longint'(int'($urandom_range(131072))) - 65536;
      else if (roll < 85)
         return longint'($urandom() & 32'h3FFFF);
      else if (roll < 92)
         return 65536;
      else
         return -65536;
   endfunction

   function automatic wave_item_type random_wave();
      longint x, y, amp;
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) begin
         x = longint'($urandom);
         y = longint'($urandom);
      end else begin
         x = longint'(int'($urandom_range(32'h0020_0000))) - 64'sd1048576;
         y = longint'(int'($urandom_range(32'h0020_0000))) - 64'sd1048576;
      end
      roll = $urandom_range(99);
      if (roll < 10)
         amp = 0;
      else if (roll < 20)
         amp = 24'hFF_FFFF;
      else
         amp = longint'($urandom_range(24'hFF_FFFF));
      return make_wave(x, y, random_dir(), random_dir(), amp, random_field(), random_field());
   endfunction

   // offer one transaction starting at a falling edge, return at a falling edge
   task send_wave(wave_item_type it);
      while (!steady && $urandom_range(99) < 36) begin
         req_tvalid = 1'b0;
         @(posedge clock);
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = pack_wave(it);
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.note_input(it);
      @(negedge clock);
      steady = (sb.inputs_seen >= 250 && sb.inputs_seen < 700);
   endtask

   // result side: random back pressure and one long hold-off
   initial begin : result_sink
      bit held;
      held = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (!held && sb.inputs_seen >= 300) begin
            held = 1'b1;
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready = steady || ($urandom_range(99) >= 36);
         @(negedge clock);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("no transaction for %0d cycles, %0d results outstanding",
            quiet_cycles, sb.pending_fields.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      wave_item_type directed[$];
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      steady = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero, both rails of every field
      directed.push_back(make_wave(0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_wave(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 65536, 65536,
         24'hFF_FFFF, FIELD_MAX, FIELD_MAX));
      directed.push_back(make_wave(-64'sd2147483648, -64'sd2147483648, -65536, -65536,
         0, FIELD_MIN, FIELD_MIN));
      // directions past unit length, full 18-bit range
      directed.push_back(make_wave(12345678, -7654321, 131071, -131072,
         24'h01_0000, 0, 0));
      directed.push_back(make_wave(-64'sd2147483648, 32'sh7FFF_FFFF, -131072, 131071,
         24'hFF_FFFF, 0, 0));
      // a phase just under one radian and a large phase wrapping many turns
      directed.push_back(make_wave(32'sh7FFF_FFFF, -64'sd2147483648, 1, -1,
         24'h80_0000, 0, 0));
      directed.push_back(make_wave(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 131071, 131071,
         24'h12_3456, 0, 0));
      // saturation of each part in each direction
      directed.push_back(make_wave(0, 0, 65536, 65536, 24'hFF_FFFF, FIELD_MAX, 0));
      directed.push_back(make_wave(205887, 0, 65536, 0, 24'hFF_FFFF, FIELD_MIN, 0));
      directed.push_back(make_wave(102944, 0, 65536, 0, 24'hFF_FFFF, 0, FIELD_MIN));
      directed.push_back(make_wave(-102944, 0, 65536, 0, 24'hFF_FFFF, 0, FIELD_MAX));
      // quarter turns around the fold line, through y
      directed.push_back(make_wave(0, 102944, 0, 65536, 24'h01_0000, 0, 0));
      directed.push_back(make_wave(0, 308831, 0, 65536, 24'h01_0000, 0, 0));
      directed.push_back(make_wave(0, 102943, 0, -65536, 24'h01_0000, 0, 0));
      directed.push_back(make_wave(205887, 205887, 65536, -65536, 24'hFF_FFFF,
         FIELD_MAX, FIELD_MIN));
      directed_count = directed.size();
      foreach (directed[i])
         send_wave(directed[i]);

      for (int n = 0; n < RANDOM_ITEMS; n++)
         send_wave(random_wave());
      req_tvalid = 1'b0;
      steady = 1'b0;

      // drain, then let any stray result show up
      while (sb.pending_fields.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending_fields.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending_fields.size()));

      $display("run covered %0d transactions (%0d directed, %0d random), %0d results checked",
         sb.inputs_seen, directed_count, RANDOM_ITEMS, sb.results_seen);
      $display("saturated parts: %0d; output held off %0d cycles under full input load",
         sb.saturations, HOLD_CYCLES);
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[sim.f]
hdl/pwpa_pkg.sv
hdl/pwpa_phase.sv
hdl/pwpa_cordic_stage.sv
hdl/pwpa_mix.sv
hdl/plane_wave_phase_accumulate.sv
test/plane_wave_phase_accumulate_test.sv
